[rtl/core/sps_pkg.sv]
// shared constants, codes and types of the stepper phase sequencer
`default_nettype none

package sps_pkg;

    // fixed geometry of the pattern table and the coil channels
    localparam int NUM_COLUMNS  = 4;
    localparam int NUM_CHANNELS = 4;
    localparam int MAX_ROWS     = 8;
    localparam int QUEUE_DEPTH  = 8;

    localparam int ROW_W     = 3;
    localparam int LEN_W     = 4;
    localparam int IV_W      = 2;
    localparam int COL_IDX_W = 2;
    localparam int CHAN_W    = 2;
    localparam int STEP_W    = 16;
    localparam int LEVEL_W   = 13;

    // drive levels and the endless spin move
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(4096);
    localparam logic [STEP_W-1:0]  SPIN_STEPS = STEP_W'(999);

    // opcodes carried in tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_SPIN = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_CHANNEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_NEGATIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_PRESENT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_PWM         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LEVEL       = 3'd7;

    // stream payload widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    // output tdata bit positions
    localparam int O_ON_LSB    = 0;
    localparam int O_LEVEL_LSB = 4;
    localparam int O_POS_LSB   = 17;
    localparam int O_NEG_LSB   = 21;
    localparam int O_BUSY_BIT  = 25;
    localparam int O_DROP_BIT  = 26;
    localparam int O_PAD_W     = 5;

    // queue control handed from the sequencer to the command queue
    typedef struct packed {
        logic clear;
        logic load_single;
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

[rtl/core/sps_cmd_queue.sv]
// circular queue of pending step commands
`default_nettype none

module sps_cmd_queue #(
    parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sps_pkg::t_q_ctrl            i_ctrl,
    input  wire logic [sps_pkg::STEP_W-1:0]  i_data,
    output logic      [sps_pkg::STEP_W-1:0]  o_head_data,
    output logic                             o_empty,
    output logic                             o_full,
    output logic                             o_pending_next
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [sps_pkg::STEP_W-1:0] r_mem [QUEUE_DEPTH];
    logic [sps_pkg::STEP_W-1:0] r_head_data;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W:0]   wr_sum, head_inc;
    logic [PTR_W-1:0] wr_idx, head_wrap, waddr;
    logic             we;

    // tail slot and next head with wrap at the depth
    always_comb begin
        wr_sum   = {1'b0, r_head} + (PTR_W+1)'(r_count);
        head_inc = {1'b0, r_head} + (PTR_W+1)'(1);
        if (wr_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            wr_idx = PTR_W'(wr_sum - (PTR_W+1)'(QUEUE_DEPTH));
        end else begin
            wr_idx = wr_sum[PTR_W-1:0];
        end
        if (head_inc >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            head_wrap = '0;
        end else begin
            head_wrap = head_inc[PTR_W-1:0];
        end
    end

    // pointer and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        we      = 1'b0;
        waddr   = wr_idx;
        priority if (i_ctrl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_ctrl.load_single) begin
            we      = 1'b1;
            waddr   = '0;
            n_head  = '0;
            n_count = CNT_W'(1);
        end else if (i_ctrl.push) begin
            we      = 1'b1;
            n_count = r_count + CNT_W'(1);
        end else if (i_ctrl.pop) begin
            n_head  = head_wrap;
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // entry storage, head entry read at the next head with write bypass
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_data;
        end
        if (we && waddr == n_head) begin
            r_head_data <= i_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_head_data    = r_head_data;
    assign o_empty        = (r_count == '0);
    assign o_full         = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign o_pending_next = (n_count != '0);

endmodule

`default_nettype wire

[rtl/core/sps_row_drive.sv]
// decode of one pattern row into channel drives and bridge pin states
`default_nettype none

module sps_row_drive (
    input  wire logic [sps_pkg::ROW_W-1:0]                      i_row,
    input  wire logic [31:0]                                    i_pattern,
    input  wire logic [sps_pkg::NUM_COLUMNS*sps_pkg::CHAN_W-1:0] i_col_chan,
    input  wire logic [sps_pkg::NUM_COLUMNS-1:0]                i_col_neg,
    input  wire logic [sps_pkg::NUM_CHANNELS-1:0]               i_bridge_present,
    input  wire logic [2*sps_pkg::NUM_CHANNELS-1:0]             i_bridge,
    output logic      [sps_pkg::NUM_CHANNELS-1:0]               o_on,
    output logic      [2*sps_pkg::NUM_CHANNELS-1:0]             o_bridge
);

    logic [sps_pkg::NUM_CHANNELS-1:0] on, pos, neg;
    logic [sps_pkg::CHAN_W-1:0]       ch;

    // columns in order, the last active column on a channel sets its pins
    always_comb begin
        on  = '0;
        pos = i_bridge[sps_pkg::NUM_CHANNELS-1:0];
        neg = i_bridge[2*sps_pkg::NUM_CHANNELS-1:sps_pkg::NUM_CHANNELS];
        ch  = '0;
        for (int c = 0; c < sps_pkg::NUM_COLUMNS; c++) begin
            if (i_pattern[{i_row, sps_pkg::COL_IDX_W'(c)}]) begin
                ch     = i_col_chan[c*sps_pkg::CHAN_W +: sps_pkg::CHAN_W];
                on[ch] = 1'b1;
                if (i_bridge_present[ch]) begin
                    if (i_col_neg[c]) begin
                        pos[ch] = 1'b0;
                        neg[ch] = 1'b1;
                    end else begin
                        pos[ch] = 1'b1;
                        neg[ch] = 1'b0;
                    end
                end
            end
        end
    end

    assign o_on     = on;
    assign o_bridge = {neg, pos};

endmodule

`default_nettype wire

[rtl/core/stepper_phase_sequencer.sv]
// top level of the stepper phase sequencer: input register, sequencer state, result register
`default_nettype none

// Takes one command transaction per clock (phase tick, queue step, spin, stop)
// and returns exactly one result transaction for each. A command is held in
// the input register, then the whole state update (queue, move, row index,
// bridge pins) is done combinationally on its way into the result register,
// and the sustained rate is one command per cycle while the result side keeps
// taking. The input side stays ready while a result waits, until both the
// input and the result register are full. Each tick drives at most one pattern
// row; a step lasts seq_length (held to 1..8) / step_interval ticks. The user
// is to write configuration through the plain write port while the block is
// idle; the block itself does not enforce it. step_interval writes of 0 or 3 are ignored.
module stepper_phase_sequencer #(
    parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // command stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // step_count[15:0], spin_reverse[16], zero fill
    input  wire logic [sps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  wire logic [sps_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // channel_on[3:0], drive_level[16:4], bridge_pos[20:17], bridge_neg[24:21],
    // busy_res[25], dropped[26], zero fill
    output logic      [sps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NCH = sps_pkg::NUM_CHANNELS;

    // configuration registers
    logic [sps_pkg::LEN_W-1:0]   r_seq_length;
    logic [sps_pkg::IV_W-1:0]    r_step_interval;
    logic [31:0]                 r_pattern_table;
    logic [7:0]                  r_column_channel;
    logic [3:0]                  r_column_negative;
    logic [3:0]                  r_bridge_present;
    logic                        r_use_pwm;
    logic [sps_pkg::LEVEL_W-1:0] r_pwm_level;

    // input register
    logic                        r_in_valid;
    logic [1:0]                  r_in_op;
    logic [sps_pkg::STEP_W-1:0]  r_in_count;
    logic                        r_in_rev;

    // sequencer state
    logic [sps_pkg::ROW_W-1:0]   r_row, n_row;
    logic                        r_rev, n_rev;
    logic [sps_pkg::STEP_W-1:0]  r_steps, n_steps;
    logic [sps_pkg::LEN_W-1:0]   r_phases, n_phases;
    logic                        r_active, n_active;
    logic                        r_spin, n_spin;
    logic [2*NCH-1:0]            r_bridge, n_bridge;

    // result register
    logic                        r_out_valid;
    logic [NCH-1:0]              r_out_on, n_out_on;
    logic [sps_pkg::LEVEL_W-1:0] r_out_level, n_out_level;
    logic [2*NCH-1:0]            r_out_bridge;
    logic                        r_out_busy, n_out_busy;
    logic                        r_out_drop, n_out_drop;

    logic                        in_fire, fire;
    logic [sps_pkg::LEN_W-1:0]   len_eff, nps, iv4, a_phases, ph_dec;
    logic                        start, cmd_neg, a_rev, a_active;
    logic [sps_pkg::STEP_W-1:0]  a_steps, cmd, steps_dec;
    logic [sps_pkg::LEN_W-1:0]   row_fwd, row_ext;
    logic [sps_pkg::ROW_W-1:0]   row_adv;
    logic [sps_pkg::LEVEL_W-1:0] level_eff;

    sps_pkg::t_q_ctrl            q_ctrl;
    logic [sps_pkg::STEP_W-1:0]  q_wdata, q_head;
    logic                        q_empty, q_full, q_pending_next;
    logic [NCH-1:0]              drv_on;
    logic [2*NCH-1:0]            drv_bridge;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length      <= sps_pkg::LEN_W'(4);
            r_step_interval   <= sps_pkg::IV_W'(1);
            r_pattern_table   <= '0;
            r_column_channel  <= 8'd228;
            r_column_negative <= '0;
            r_bridge_present  <= '0;
            r_use_pwm         <= 1'b0;
            r_pwm_level       <= sps_pkg::FULL_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sps_pkg::REG_SEQ_LENGTH: begin
                    r_seq_length <= i_cfg_data[sps_pkg::LEN_W-1:0];
                end
                sps_pkg::REG_STEP_INTERVAL: begin
                    if (i_cfg_data[1:0] == 2'd1 || i_cfg_data[1:0] == 2'd2) begin
                        r_step_interval <= i_cfg_data[sps_pkg::IV_W-1:0];
                    end
                end
                sps_pkg::REG_PATTERN_TABLE: begin
                    r_pattern_table <= i_cfg_data[31:0];
                end
                sps_pkg::REG_COLUMN_CHANNEL: begin
                    r_column_channel <= i_cfg_data[7:0];
                end
                sps_pkg::REG_COLUMN_NEGATIVE: begin
                    r_column_negative <= i_cfg_data[3:0];
                end
                sps_pkg::REG_BRIDGE_PRESENT: begin
                    r_bridge_present <= i_cfg_data[3:0];
                end
                sps_pkg::REG_USE_PWM: begin
                    r_use_pwm <= i_cfg_data[0];
                end
                sps_pkg::REG_PWM_LEVEL: begin
                    r_pwm_level <= i_cfg_data[sps_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_op    <= s_axis_tuser[1:0];
            r_in_count <= s_axis_tdata[sps_pkg::STEP_W-1:0];
            r_in_rev   <= s_axis_tdata[sps_pkg::STEP_W];
        end
    end

    // effective length, phases per step and drive level
    always_comb begin
        if (r_seq_length == '0) begin
            len_eff = sps_pkg::LEN_W'(1);
        end else if (r_seq_length > sps_pkg::LEN_W'(sps_pkg::MAX_ROWS)) begin
            len_eff = sps_pkg::LEN_W'(sps_pkg::MAX_ROWS);
        end else begin
            len_eff = r_seq_length;
        end
        iv4 = sps_pkg::LEN_W'(r_step_interval);
        nps = (r_step_interval == sps_pkg::IV_W'(2)) ? (len_eff >> 1) : len_eff;
        if (r_use_pwm) begin
            level_eff = (r_pwm_level > sps_pkg::FULL_LEVEL) ? sps_pkg::FULL_LEVEL
                                                            : r_pwm_level;
        end else begin
            level_eff = sps_pkg::FULL_LEVEL;
        end
    end

    // row index advance in the move direction
    always_comb begin
        row_ext = {1'b0, r_row};
        row_fwd = row_ext + iv4;
        if (!a_rev) begin
            row_adv = (row_fwd >= len_eff) ? '0 : row_fwd[sps_pkg::ROW_W-1:0];
        end else if (row_ext < iv4 || (row_ext - iv4) >= len_eff) begin
            row_adv = (len_eff >= iv4) ? sps_pkg::ROW_W'(len_eff - iv4) : '0;
        end else begin
            row_adv = sps_pkg::ROW_W'(row_ext - iv4);
        end
    end

    // start of the oldest queued command on a tick
    always_comb begin
        cmd     = q_head;
        cmd_neg = cmd[sps_pkg::STEP_W-1];
        start   = (r_in_op == sps_pkg::OP_TICK) && !r_active && !q_empty;
        if (start) begin
            a_rev    = cmd_neg || (cmd == '0);
            a_steps  = cmd_neg ? (sps_pkg::STEP_W'(0) - cmd) : cmd;
            a_phases = nps;
            a_active = (a_steps != '0);
        end else begin
            a_rev    = r_rev;
            a_steps  = r_steps;
            a_phases = r_phases;
            a_active = r_active;
        end
        ph_dec    = a_phases - sps_pkg::LEN_W'(1);
        steps_dec = a_steps - sps_pkg::STEP_W'(1);
    end

    // next state and result of one command
    always_comb begin
        n_row       = r_row;
        n_rev       = r_rev;
        n_steps     = r_steps;
        n_phases    = r_phases;
        n_active    = r_active;
        n_spin      = r_spin;
        n_bridge    = r_bridge;
        n_out_on    = '0;
        n_out_level = '0;
        n_out_drop  = 1'b0;
        q_ctrl      = '0;
        q_wdata     = r_in_count;
        unique case (r_in_op)
            sps_pkg::OP_TICK: begin
                q_ctrl.pop = start;
                n_rev      = a_rev;
                n_steps    = a_steps;
                n_phases   = a_phases;
                n_active   = a_active;
                if (a_active) begin
                    if (a_phases == '0) begin
                        if (!r_spin) begin
                            n_active = 1'b0;
                            n_steps  = '0;
                        end
                    end else begin
                        n_out_on    = drv_on;
                        n_out_level = level_eff;
                        n_bridge    = drv_bridge;
                        n_row       = row_adv;
                        n_phases    = ph_dec;
                        if (ph_dec == '0) begin
                            if (!r_spin) begin
                                n_steps = steps_dec;
                                if (steps_dec == '0) begin
                                    n_active = 1'b0;
                                end
                            end
                            n_phases = nps;
                        end
                    end
                end
            end
            sps_pkg::OP_STEP: begin
                if (r_spin || q_full) begin
                    n_out_drop = 1'b1;
                end else begin
                    q_ctrl.push = 1'b1;
                end
            end
            sps_pkg::OP_SPIN: begin
                q_ctrl.load_single = 1'b1;
                q_wdata  = r_in_rev ? (sps_pkg::STEP_W'(0) - sps_pkg::SPIN_STEPS)
                                    : sps_pkg::SPIN_STEPS;
                n_active = 1'b0;
                n_steps  = '0;
                n_phases = '0;
                n_spin   = 1'b1;
            end
            sps_pkg::OP_STOP: begin
                q_ctrl.clear = 1'b1;
                n_active     = 1'b0;
                n_steps      = '0;
                n_phases     = '0;
                n_spin       = 1'b0;
            end
            default: begin
            end
        endcase
        if (!fire) begin
            q_ctrl = '0;
        end
        n_out_busy = n_active || n_spin || q_pending_next;
    end

    sps_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (q_ctrl),
        .i_data         (q_wdata),
        .o_head_data    (q_head),
        .o_empty        (q_empty),
        .o_full         (q_full),
        .o_pending_next (q_pending_next)
    );

    sps_row_drive u_drive (
        .i_row            (r_row),
        .i_pattern        (r_pattern_table),
        .i_col_chan       (r_column_channel),
        .i_col_neg        (r_column_negative),
        .i_bridge_present (r_bridge_present),
        .i_bridge         (r_bridge),
        .o_on             (drv_on),
        .o_bridge         (drv_bridge)
    );

    // sequencer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_rev    <= 1'b0;
            r_steps  <= '0;
            r_phases <= '0;
            r_active <= 1'b0;
            r_spin   <= 1'b0;
            r_bridge <= '0;
        end else if (fire) begin
            r_row    <= n_row;
            r_rev    <= n_rev;
            r_steps  <= n_steps;
            r_phases <= n_phases;
            r_active <= n_active;
            r_spin   <= n_spin;
            r_bridge <= n_bridge;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_on     <= n_out_on;
            r_out_level  <= n_out_level;
            r_out_bridge <= n_bridge;
            r_out_busy   <= n_out_busy;
            r_out_drop   <= n_out_drop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{sps_pkg::O_PAD_W{1'b0}}, r_out_drop, r_out_busy,
                            r_out_bridge[2*NCH-1:NCH], r_out_bridge[NCH-1:0],
                            r_out_level, r_out_on};

endmodule

`default_nettype wire

[rtl/core/sps_checker.sv]
// port level checks of the stepper phase sequencer, bound to the top level
`default_nettype none

module sps_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [sps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NCH = sps_pkg::NUM_CHANNELS;

    logic [NCH-1:0]              chk_on, chk_pos, chk_neg;
    logic [sps_pkg::LEVEL_W-1:0] chk_level;
    logic                        chk_drop;

    assign chk_on    = m_axis_tdata[sps_pkg::O_ON_LSB +: NCH];
    assign chk_level = m_axis_tdata[sps_pkg::O_LEVEL_LSB +: sps_pkg::LEVEL_W];
    assign chk_pos   = m_axis_tdata[sps_pkg::O_POS_LSB +: NCH];
    assign chk_neg   = m_axis_tdata[sps_pkg::O_NEG_LSB +: NCH];
    assign chk_drop  = m_axis_tdata[sps_pkg::O_DROP_BIT];

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the input side only backs up behind a waiting result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready) || m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // an h-bridge never drives both pins of a channel
    a_bridge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (chk_pos & chk_neg) == '0)
        else $error("bridge pin pair both high");

    // a refused command drives no phase
    a_drop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && chk_drop |-> chk_on == '0 && chk_level == '0)
        else $error("refused command drove a phase");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
